FILE: design/frhc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the framed record
// header and CRC check. No dependencies; every other design file imports it.
`default_nettype none

package frhc_pkg;

    localparam int unsigned HEADER_BYTES = 14;
    localparam int unsigned POS_W        = 34;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [31:0] MAGIC_RESET   = 32'h5046_454D;
    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam logic [31:0] MAX_LEN_RESET = 32'd67108864;

    // Header byte offsets.
    localparam logic [3:0] OFS_VER_0 = 4'd4;
    localparam logic [3:0] OFS_VER_1 = 4'd5;
    localparam logic [3:0] OFS_LEN_0 = 4'd6;
    localparam logic [3:0] OFS_LEN_1 = 4'd7;
    localparam logic [3:0] OFS_LEN_2 = 4'd8;
    localparam logic [3:0] OFS_LEN_3 = 4'd9;
    localparam logic [3:0] OFS_CRC_0 = 4'd10;
    localparam logic [3:0] OFS_CRC_1 = 4'd11;
    localparam logic [3:0] OFS_CRC_2 = 4'd12;
    localparam logic [3:0] OFS_CRC_3 = 4'd13;

    typedef enum logic [1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_MAX_LEN = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_TRAILING  = 3'd6,
        ST_CHECKSUM  = 3'd7
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] declared_length;
        logic [31:0] computed_crc;
    } verdict_word_t;

    // One finished record as the front hands it to the back.
    typedef struct packed {
        logic [POS_W-1:0] count;
        logic             magic_ok;
        logic [15:0]      version;
        logic [31:0]      length;
        logic [31:0]      header_crc;
        logic [31:0]      crc;
    } record_t;

    // Reflected CRC-32 update by one byte; reduces to an XOR network.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage

`default_nettype wire

FILE: design/framed_record_header_crc_check.sv
// Top level of the framed record header and CRC-32 check: configuration
// registers plus front, queue and back. Depends on frhc_pkg and the frhc_* modules.
//
//   channel   direction  handshake            word
//   byte      in         byte_valid/stall     byte_word_t (data_byte, last_byte)
//   verdict   out        verdict_valid/stall  verdict_word_t (status, length, crc)
//   cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// One record byte is taken every cycle unless byte_stall is high; the CRC byte
// update in the front sets that figure. A record summary enters the queue on the
// edge that takes its last byte; the back pops it, ranks the checks and passes
// the verdict into the output register once that register is free or being taken.
// byte_stall is high only while the queue is full, which happens when the verdict
// side stalls. Reset clears all control state at once; there is no clearing pass.
`default_nettype none

module framed_record_header_crc_check #(
    parameter int unsigned QUEUE_DEPTH = frhc_pkg::QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    byte_valid,
    output logic                         byte_stall,
    input  wire frhc_pkg::byte_word_t    byte_word,
    output logic                         verdict_valid,
    input  wire logic                    verdict_stall,
    output frhc_pkg::verdict_word_t      verdict_word,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [31:0]             cfg_data
);
    import frhc_pkg::*;

    logic [31:0] magic_reg;
    logic [15:0] version_reg;
    logic [31:0] max_len_reg;

    logic    push, queue_full, pop, not_empty;
    record_t push_rec, head;

    // The register file is always able to take a write. Writes to an index
    // beyond the list are accepted and dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            version_reg <= VERSION_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data[15:0];
                CFG_MAX_LEN: max_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // The front compares each magic byte as it arrives; version and length
    // are judged by the back when the verdict is formed.
    frhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .magic_word (magic_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    frhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    frhc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .not_empty          (not_empty),
        .head               (head),
        .pop                (pop),
        .expected_version   (version_reg),
        .max_payload_length (max_len_reg),
        .verdict_valid      (verdict_valid),
        .verdict_stall      (verdict_stall),
        .verdict_word       (verdict_word)
    );

endmodule

`default_nettype wire

FILE: design/frhc_front.sv
// Front part: accepts record bytes, counts them, captures the header and runs
// the CRC. Hands one record summary per last byte to the queue. Uses frhc_pkg.
`default_nettype none

module frhc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire frhc_pkg::byte_word_t byte_word,
    input  wire logic [31:0]         magic_word,
    input  wire logic                queue_full,
    output logic                     push,
    output frhc_pkg::record_t        push_rec
);
    import frhc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_ok_reg, magic_ok_next;
    logic [15:0]      ver_reg, ver_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      hcrc_reg, hcrc_next;
    logic [31:0]      crc_reg, crc_next;

    logic       accept;
    logic       in_hdr;
    logic [3:0] idx;
    logic [7:0] b;
    logic [7:0] want;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;
    assign b          = byte_word.data_byte;
    assign in_hdr     = pos_reg < POS_W'(HEADER_BYTES);
    assign idx        = pos_reg[3:0];
    assign want       = 8'(magic_word >> {idx[1:0], 3'b000});

    always_comb
    begin
        ver_next      = ver_reg;
        len_next      = len_reg;
        hcrc_next     = hcrc_reg;
        magic_ok_next = magic_ok_reg;
        crc_next      = crc_reg;
        if (!in_hdr)
        begin
            crc_next = crc_byte(crc_reg, b);
        end
        else
        begin
            case (idx)
                OFS_VER_0: ver_next[7:0]    = b;
                OFS_VER_1: ver_next[15:8]   = b;
                OFS_LEN_0: len_next[7:0]    = b;
                OFS_LEN_1: len_next[15:8]   = b;
                OFS_LEN_2: len_next[23:16]  = b;
                OFS_LEN_3: len_next[31:24]  = b;
                OFS_CRC_0: hcrc_next[7:0]   = b;
                OFS_CRC_1: hcrc_next[15:8]  = b;
                OFS_CRC_2: hcrc_next[23:16] = b;
                OFS_CRC_3: hcrc_next[31:24] = b;
                default:
                begin
                    if (b != want)
                    begin
                        magic_ok_next = 1'b0;
                    end
                end
            endcase
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    end

    always_comb
    begin
        push                = accept && byte_word.last_byte;
        push_rec.count      = pos_next;
        push_rec.magic_ok   = magic_ok_next;
        push_rec.version    = ver_next;
        push_rec.length     = len_next;
        push_rec.header_crc = hcrc_next;
        push_rec.crc        = crc_next ^ CRC_ONES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            magic_ok_reg <= 1'b1;
            ver_reg      <= '0;
            len_reg      <= '0;
            hcrc_reg     <= '0;
            crc_reg      <= CRC_ONES;
        end
        else if (accept)
        begin
            if (byte_word.last_byte)
            begin
                pos_reg      <= '0;
                magic_ok_reg <= 1'b1;
                ver_reg      <= '0;
                len_reg      <= '0;
                hcrc_reg     <= '0;
                crc_reg      <= CRC_ONES;
            end
            else
            begin
                pos_reg      <= pos_next;
                magic_ok_reg <= magic_ok_next;
                ver_reg      <= ver_next;
                len_reg      <= len_next;
                hcrc_reg     <= hcrc_next;
                crc_reg      <= crc_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/frhc_queue.sv
// Short FIFO of finished record summaries between front and back.
// Uses frhc_pkg for the record type.
`default_nettype none

module frhc_queue #(
    parameter int unsigned DEPTH = frhc_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire frhc_pkg::record_t push_rec,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output frhc_pkg::record_t      head
);
    import frhc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    record_t        mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full      = cnt_reg == CW'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/frhc_back.sv
// Back part: takes one record summary from the queue, ranks the checks and
// holds the verdict in an output register until it is taken. Uses frhc_pkg.
`default_nettype none

module frhc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   not_empty,
    input  wire frhc_pkg::record_t      head,
    output logic                        pop,
    input  wire logic [15:0]            expected_version,
    input  wire logic [31:0]            max_payload_length,
    output logic                        verdict_valid,
    input  wire logic                   verdict_stall,
    output frhc_pkg::verdict_word_t     verdict_word
);
    import frhc_pkg::*;

    logic          valid_reg;
    verdict_word_t word_reg, word_next;
    logic [POS_W-1:0] expect_cnt;
    logic          is_short;
    status_t       status;

    assign pop        = not_empty && (!valid_reg || !verdict_stall);
    assign expect_cnt = POS_W'(HEADER_BYTES) + {2'b00, head.length};
    assign is_short   = head.count < POS_W'(HEADER_BYTES);

    always_comb
    begin
        if (is_short)
        begin
            status = ST_SHORT;
        end
        else if (!head.magic_ok)
        begin
            status = ST_MAGIC;
        end
        else if (head.version != expected_version)
        begin
            status = ST_VERSION;
        end
        else if (head.length > max_payload_length)
        begin
            status = ST_TOO_LARGE;
        end
        else if (head.count < expect_cnt)
        begin
            status = ST_TRUNCATED;
        end
        else if (head.count > expect_cnt)
        begin
            status = ST_TRAILING;
        end
        else if (head.crc != head.header_crc)
        begin
            status = ST_CHECKSUM;
        end
        else
        begin
            status = ST_OK;
        end
        word_next.status          = status;
        word_next.declared_length = is_short ? 32'd0 : head.length;
        word_next.computed_crc    = head.crc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !verdict_stall)
        begin
            valid_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= word_next;
        end
    end

    assign verdict_valid = valid_reg;
    assign verdict_word  = word_reg;

endmodule

`default_nettype wire

FILE: test/verdict_scoreboard_pkg.sv
// Scoreboard class for the framed record header and CRC check testbench.
// Depends on frhc_pkg for the word types, status codes and CRC constants.
package verdict_scoreboard_pkg;

    import frhc_pkg::*;

    class verdict_scoreboard;

        // Register copies, as last written through the configuration port.
        logic [31:0] magic_word;
        logic [15:0] expected_version;
        logic [31:0] max_payload_length;

        // Per-record state.
        logic [POS_W-1:0] byte_count;
        bit               magic_ok;
        logic [15:0]      hdr_version;
        logic [31:0]      hdr_length;
        logic [31:0]      hdr_crc;
        logic [31:0]      payload_crc;

        verdict_word_t expected_verdicts[$];
        int            mismatches;
        int            records_checked;
        int            status_seen[8];

        function new();
            magic_word         = MAGIC_RESET;
            expected_version   = VERSION_RESET;
            max_payload_length = MAX_LEN_RESET;
            mismatches         = 0;
            records_checked    = 0;
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
            clear_record();
        endfunction

        function void clear_record();
            byte_count  = '0;
            magic_ok    = 1'b1;
            hdr_version = '0;
            hdr_length  = '0;
            hdr_crc     = '0;
            payload_crc = CRC_ONES;
        endfunction

        // Reflected CRC-32, one data bit at a time, low bit first.
        static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] data);
            logic [31:0] r;
            logic [7:0]  d;
            r = crc;
            d = data;
            for (int i = 0; i < 8; i++)
            begin
                if (r[0] ^ d[0])
                begin
                    r = (r >> 1) ^ CRC_POLY;
                end
                else
                begin
                    r = r >> 1;
                end
                d = d >> 1;
            end
            return r;
        endfunction

        function void apply_register(logic [1:0] index, logic [31:0] value);
            case (index)
                CFG_MAGIC:   magic_word = value;
                CFG_VERSION: expected_version = value[15:0];
                CFG_MAX_LEN: max_payload_length = value;
                default:     ;
            endcase
        endfunction

        // Folds one accepted byte into the record and, on the last byte,
        // queues the verdict the block has to give.
        function void take_byte(byte_word_t w);
            int unsigned      p;
            longint unsigned  total;
            longint unsigned  needed;
            logic [31:0]      crc_out;
            verdict_word_t    v;
            status_t          st;
            p = (byte_count < HEADER_BYTES) ? int'(byte_count) : HEADER_BYTES;
            if (p < OFS_VER_0)
            begin
                if (w.data_byte != magic_word[8*p +: 8])
                begin
                    magic_ok = 1'b0;
                end
            end
            else if (p < OFS_LEN_0)
            begin
                hdr_version[8*(p - OFS_VER_0) +: 8] = w.data_byte;
            end
            else if (p < OFS_CRC_0)
            begin
                hdr_length[8*(p - OFS_LEN_0) +: 8] = w.data_byte;
            end
            else if (p < HEADER_BYTES)
            begin
                hdr_crc[8*(p - OFS_CRC_0) +: 8] = w.data_byte;
            end
            else
            begin
                payload_crc = crc_step(payload_crc, w.data_byte);
            end
            if (byte_count != POS_MAX)
            begin
                byte_count = byte_count + 1'b1;
            end
            if (w.last_byte)
            begin
                total   = 64'(byte_count);
                needed  = 64'(HEADER_BYTES) + 64'(hdr_length);
                crc_out = payload_crc ^ CRC_ONES;
                if (total < HEADER_BYTES)
                    st = ST_SHORT;
                else if (!magic_ok)
                    st = ST_MAGIC;
                else if (hdr_version != expected_version)
                    st = ST_VERSION;
                else if (hdr_length > max_payload_length)
                    st = ST_TOO_LARGE;
                else if (total < needed)
                    st = ST_TRUNCATED;
                else if (total > needed)
                    st = ST_TRAILING;
                else if (crc_out != hdr_crc)
                    st = ST_CHECKSUM;
                else
                    st = ST_OK;
                v.status          = st;
                v.declared_length = (st == ST_SHORT) ? 32'd0 : hdr_length;
                v.computed_crc    = crc_out;
                expected_verdicts = {expected_verdicts, v};
                clear_record();
            end
        endfunction

        function void complain(string msg);
            if (mismatches < 10)
            begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
            mismatches++;
        endfunction

        function void check_verdict(verdict_word_t got);
            verdict_word_t want;
            status_t       want_st;
            if (expected_verdicts.size() == 0)
            begin
                complain($sformatf("verdict with none pending: status %0d length %h crc %h",
                                   got.status, got.declared_length, got.computed_crc));
                return;
            end
            want = expected_verdicts.pop_front();
            want_st = status_t'(want.status);
            status_seen[want.status]++;
            if (got.status !== want.status || got.declared_length !== want.declared_length
                || got.computed_crc !== want.computed_crc)
            begin
                complain($sformatf("verdict %0d: expected %s len %h crc %h, got %0d len %h crc %h",
                                   records_checked, want_st.name(),
                                   want.declared_length, want.computed_crc,
                                   got.status, got.declared_length, got.computed_crc));
            end
            records_checked++;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

    endclass

endpackage

FILE: test/testbench.sv
// Self-checking testbench for framed_record_header_crc_check: drives records
// byte by byte, predicts every verdict and compares it. Depends on frhc_pkg,
// verdict_scoreboard_pkg and the design files.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import frhc_pkg::*;
    import verdict_scoreboard_pkg::*;

    // Index 3 is not a register; writes to it must be dropped.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int LIMIT_CYCLES    = 300000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 300;
    localparam int FIFO_LIMIT      = 32;
    localparam int WELL_FORMED_PCT = 65;
    localparam int PHASE_ITEMS     = 250;

    // Ways in which a random record is spoiled.
    typedef enum int unsigned {
        FLAW_SHORT,
        FLAW_NOISE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_TOO_LARGE,
        FLAW_TRUNCATED,
        FLAW_TRAILING,
        FLAW_CHECKSUM
    } record_flaw_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          byte_valid;
    logic          byte_stall;
    byte_word_t    byte_word;
    logic          verdict_valid;
    logic          verdict_stall;
    verdict_word_t verdict_word;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [31:0]   cfg_data;

    verdict_scoreboard book;

    // Byte words waiting to be offered, in order.
    byte_word_t byte_fifo[$];
    int         bytes_queued = 0;
    bit         byte_taken = 1'b0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    bit         long_hold_req = 1'b0;
    int         cycle_count = 0;

    always #5 clk = ~clk;

    framed_record_header_crc_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_word     (byte_word),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict_word  (verdict_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Everything is sampled at the rising edge, before the design's own
    // updates land. The verdict is checked first; it can only belong to an
    // earlier last byte, so the order inside this block is never a factor.
    always @(posedge clk)
    begin : word_monitor
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            book.check_verdict(verdict_word);
        end
        byte_taken = rst_n && byte_valid && !byte_stall;
        if (byte_taken)
        begin
            book.take_byte(byte_word);
        end
    end

    // Sender. A new word is chosen at the falling edge only when no word is
    // on offer or the one on offer was just taken, so a stalled word stays
    // put and valid never looks at stall. The random gap lands anywhere in a
    // record: header, payload or last byte.
    initial
    begin : byte_driver
        byte_valid = 1'b0;
        byte_word  = '0;
        forever
        begin
            @(negedge clk);
            if (!byte_valid || byte_taken)
            begin
                if (byte_fifo.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    byte_word  <= byte_fifo.pop_front();
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Stall is redrawn every falling edge. On request it holds
    // stall high for a long stretch, counted here, so that the verdict queue
    // fills and the block has to push back on the byte side.
    initial
    begin : verdict_receiver
        int hold_left;
        verdict_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                verdict_stall <= 1'b1;
                hold_left = LONG_HOLD;
                while (hold_left != 0)
                begin
                    @(negedge clk);
                    hold_left--;
                end
            end
            verdict_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // A run that hangs ends here.
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d verdicts still pending",
                 cycle_count, book.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Queues one byte word; keeps the queue short so that the stimulus
    // stays close to what is actually on the wire.
    task automatic push_byte(input logic [7:0] data, input logic last);
        byte_word_t w;
        while (byte_fifo.size() >= FIFO_LIMIT)
        begin
            @(posedge clk);
        end
        w.data_byte = data;
        w.last_byte = last;
        byte_fifo = {byte_fifo, w};
        bytes_queued++;
    endtask

    // Queues header bytes first..upto of the 14-byte header image; the
    // last flag goes on byte upto when mark_last is set.
    task automatic push_header_bytes(input logic [111:0] hdr, input int first,
                                     input int upto, input bit mark_last);
        for (int k = first; k <= upto; k++)
        begin
            push_byte(hdr[8*k +: 8], mark_last && (k == upto));
        end
    endtask

    // Queues n random bytes with the last flag on the final one.
    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            push_byte(8'($urandom), i == n - 1);
        end
    endtask

    // Queues a whole record: header with the given fields, then sent random
    // payload bytes. The header CRC covers the bytes sent, xored with crc_x.
    task automatic push_record(input logic [31:0] mg, input logic [15:0] ver,
                               input logic [31:0] len, input int sent,
                               input logic [31:0] crc_x);
        logic [7:0]   body[$];
        logic [31:0]  crc;
        logic [111:0] hdr;
        crc = CRC_ONES;
        for (int i = 0; i < sent; i++)
        begin
            body = {body, 8'($urandom)};
            crc = verdict_scoreboard::crc_step(crc, body[i]);
        end
        crc = (crc ^ CRC_ONES) ^ crc_x;
        hdr = {crc, len, ver, mg};
        push_header_bytes(hdr, 0, HEADER_BYTES - 1, sent == 0);
        for (int i = 0; i < sent; i++)
        begin
            push_byte(body[i], i == sent - 1);
        end
    endtask

    // Mostly short payloads, now and then a longer one, never above the
    // current maximum.
    function automatic logic [31:0] pick_length();
        logic [31:0] len;
        len = ($urandom_range(15) == 0) ? $urandom_range(120) : $urandom_range(20);
        if (len > book.max_payload_length)
        begin
            len = book.max_payload_length;
        end
        return len;
    endfunction

    // One random record: well formed with random content most of the time,
    // otherwise spoiled in one way so that every verdict comes up.
    task automatic gen_record();
        record_flaw_t flaw;
        logic [31:0]  mg;
        logic [31:0]  len;
        logic [31:0]  crc_x;
        logic [15:0]  ver;
        int           sent;
        mg    = book.magic_word;
        ver   = book.expected_version;
        len   = pick_length();
        sent  = int'(len);
        crc_x = '0;
        if ($urandom_range(99) >= WELL_FORMED_PCT)
        begin
            flaw = record_flaw_t'($urandom_range(FLAW_CHECKSUM));
            case (flaw)
                FLAW_SHORT:
                begin
                    push_noise($urandom_range(13, 1));
                    return;
                end
                FLAW_NOISE:
                begin
                    push_noise($urandom_range(40, 1));
                    return;
                end
                FLAW_MAGIC:   mg = mg ^ (32'h1 << $urandom_range(31));
                FLAW_VERSION: ver = ver ^ 16'($urandom_range(65535, 1));
                FLAW_TOO_LARGE:
                begin
                    len = book.max_payload_length + 32'($urandom_range(16, 1));
                    if (len <= book.max_payload_length)
                    begin
                        len = 32'hFFFF_FFFF;
                    end
                    sent = $urandom_range(8);
                end
                FLAW_TRUNCATED:
                begin
                    if (len == 0 && book.max_payload_length != 0)
                    begin
                        len = 32'd1;
                    end
                    sent = (len == 0) ? 1 : $urandom_range(int'(len) - 1);
                end
                FLAW_TRAILING: sent = int'(len) + $urandom_range(4, 1);
                FLAW_CHECKSUM: crc_x = 32'h1 << $urandom_range(31);
                default:       ;
            endcase
        end
        push_record(mg, ver, len, sent, crc_x);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        book.apply_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued word is taken, every verdict has come back,
    // and the pipeline has had time to empty behind records with no verdict.
    task automatic wait_idle();
        while (byte_fifo.size() != 0 || byte_valid || book.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers, sets the idling mix, then sends random
    // records until the phase's share of bytes has been queued.
    task automatic run_phase(input logic [31:0] mg, input logic [15:0] ver,
                             input logic [31:0] max_len, input int idle_pct,
                             input int stall_pct);
        int target;
        wait_idle();
        write_register(CFG_MAGIC, mg);
        write_register(CFG_VERSION, {16'($urandom), ver});
        write_register(CFG_MAX_LEN, max_len);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target = bytes_queued + PHASE_ITEMS;
        while (bytes_queued < target)
        begin
            gen_record();
        end
    endtask

    initial
    begin : stimulus
        logic [111:0] hdr;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        book      = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed records under the reset settings, together covering every verdict.
        push_record(MAGIC_RESET, VERSION_RESET, 32'd0, 0, '0);
        push_record(MAGIC_RESET, VERSION_RESET, 32'd6, 6, '0);
        push_byte(8'hFF, 1'b1);
        for (int k = 0; k < 13; k++)
        begin
            push_byte(8'h00, k == 12);
        end
        push_record(MAGIC_RESET ^ 32'h8000_0000, VERSION_RESET, 32'd2, 2, '0);
        push_record(MAGIC_RESET, 16'hFFFF, 32'd2, 2, '0);
        push_record(MAGIC_RESET, VERSION_RESET, 32'hFFFF_FFFF, 2, '0);
        push_record(MAGIC_RESET, VERSION_RESET, 32'd8, 3, '0);
        push_record(MAGIC_RESET, VERSION_RESET, 32'd2, 5, '0);
        push_record(MAGIC_RESET, VERSION_RESET, 32'd4, 4, 32'h0000_0001);
        // Magic wins over every later check when several fail at once.
        push_record(MAGIC_RESET ^ 32'h1, 16'h0000, 32'hFFFF_FFFF, 0, '0);

        // Registers change in the middle of a record. The magic bytes were
        // already compared, so a new magic has no effect on this record,
        // while the version is compared only at the verdict and must match
        // the value written mid-way.
        hdr = {32'd0, 32'd0, 16'd9, MAGIC_RESET};
        push_header_bytes(hdr, 0, 7, 1'b0);
        wait_idle();
        write_register(CFG_MAGIC, 32'hA5A5_5A5A);
        write_register(CFG_VERSION, 32'hFFFF_0009);
        push_header_bytes(hdr, 8, HEADER_BYTES - 1, 1'b1);

        // Back to the reset values; a write to the unused index is dropped.
        wait_idle();
        write_register(CFG_MAGIC, MAGIC_RESET);
        write_register(CFG_VERSION, 32'(VERSION_RESET));
        write_register(CFG_MAX_LEN, MAX_LEN_RESET);
        write_register(CFG_UNUSED, 32'hFFFF_FFFF);
        push_record(MAGIC_RESET, VERSION_RESET, 32'd3, 3, '0);

        // Random phases, each under its own settings and idling mix.
        run_phase(MAGIC_RESET, VERSION_RESET, MAX_LEN_RESET, 0, 0);
        run_phase(32'h0000_0000, 16'h0000, 32'h0000_0000, 70, 0);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 70);
        // With no length limit, the largest declared length is merely truncated.
        push_record(book.magic_word, book.expected_version, 32'hFFFF_FFFF, 3, '0);
        run_phase($urandom, 16'($urandom), $urandom_range(30), 29, 29);

        // Back-pressure: the receiver holds off while the sender keeps
        // offering short records, so the verdict queue fills and byte_stall
        // has to rise.
        wait_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        long_hold_req      = 1'b1;
        for (int r = 0; r < 30; r++)
        begin
            push_noise($urandom_range(3, 1));
        end
        for (int r = 0; r < 4; r++)
        begin
            gen_record();
        end

        // Drain: nothing may be pending, and nothing may turn up afterwards.
        while (byte_fifo.size() != 0 || byte_valid || book.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d record bytes and %0d verdicts over five register settings",
                 bytes_queued, book.records_checked);
        $display("Verdicts: ok %0d short %0d magic %0d version %0d large %0d",
                 book.status_seen[ST_OK], book.status_seen[ST_SHORT],
                 book.status_seen[ST_MAGIC], book.status_seen[ST_VERSION],
                 book.status_seen[ST_TOO_LARGE]);
        $display("          trunc %0d trail %0d crc %0d",
                 book.status_seen[ST_TRUNCATED], book.status_seen[ST_TRAILING],
                 book.status_seen[ST_CHECKSUM]);
        if (book.mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d mismatches in total", book.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
